@@ sv/kcl_pkg.sv @@
// Shared types and constants of the keypad code lock.
`timescale 1ns / 1ps
`default_nettype none
package kcl_pkg;

  localparam int CODE_LENGTH_DEF = 4;
  localparam int KEY_W           = 4;
  localparam int FAIL_W          = 3;
  localparam int EV_W            = 3;

  localparam logic [FAIL_W-1:0] MAX_FAIL_RESET = 3'd3;

  localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [KEY_W-1:0] KEY_STAR      = 4'd10;
  localparam logic [KEY_W-1:0] KEY_HASH      = 4'd11;

  typedef enum logic [EV_W-1:0] {
    EV_NONE       = 3'd0,
    EV_DIGIT      = 3'd1,
    EV_SETMODE    = 3'd2,
    EV_CODESET    = 3'd3,
    EV_OPEN       = 3'd4,
    EV_WRONG      = 3'd5,
    EV_LOCKOUT    = 3'd6,
    EV_INCOMPLETE = 3'd7
  } event_t;

  typedef struct packed {
    event_t              ev;
    logic [FAIL_W-1:0]   failures;
    logic                present;
  } kcl_result_t;

endpackage
`default_nettype wire

@@ sv/kcl_key_if.sv @@
// Key input channel: valid/ready plus one key code per beat.
`timescale 1ns / 1ps
`default_nettype none
interface kcl_key_if;
  logic                       valid;
  logic                       ready;
  logic [kcl_pkg::KEY_W-1:0]  key_code;

  modport source (output valid, output key_code, input ready);
  modport sink   (input valid, input key_code, output ready);
endinterface
`default_nettype wire

@@ sv/kcl_evt_if.sv @@
// Result channel: valid/ready plus event, failure count and code flag per beat.
`timescale 1ns / 1ps
`default_nettype none
interface kcl_evt_if;
  logic                        valid;
  logic                        ready;
  logic [kcl_pkg::EV_W-1:0]    event_res;
  logic [kcl_pkg::FAIL_W-1:0]  failures_now;
  logic                        code_present;

  modport source (output valid, output event_res, output failures_now,
                  output code_present, input ready);
  modport sink   (input valid, input event_res, input failures_now,
                  input code_present, output ready);
endinterface
`default_nettype wire

@@ sv/kcl_cfg_if.sv @@
// Configuration write channel: valid/ready plus the failure limit.
`timescale 1ns / 1ps
`default_nettype none
interface kcl_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [kcl_pkg::FAIL_W-1:0]  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ sv/kcl_core.sv @@
// Lock state registers and the per-key next-state and event logic.
`timescale 1ns / 1ps
`default_nettype none
module kcl_core #(
  parameter int CODE_LENGTH = kcl_pkg::CODE_LENGTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire logic [kcl_pkg::KEY_W-1:0]   key,
  input  wire logic [kcl_pkg::FAIL_W-1:0]  max_failures,
  output kcl_pkg::kcl_result_t             res
);

  localparam int CNT_W = $clog2(CODE_LENGTH + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(CODE_LENGTH);

  logic [kcl_pkg::KEY_W-1:0]   entry_r  [CODE_LENGTH];
  logic [kcl_pkg::KEY_W-1:0]   stored_r [CODE_LENGTH];
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic                        code_set_r, code_set_nxt;
  logic                        set_mode_r, set_mode_nxt;
  logic [kcl_pkg::FAIL_W-1:0]  fail_r, fail_nxt, fail_inc;
  logic                        match;
  logic                        wr_digit, wr_code;
  kcl_pkg::event_t             ev;

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      if (entry_r[i] != stored_r[i]) match = 1'b0;
    end
  end

  assign fail_inc = fail_r + 1'b1;

  always_comb begin
    count_nxt    = count_r;
    code_set_nxt = code_set_r;
    set_mode_nxt = set_mode_r;
    fail_nxt     = fail_r;
    wr_digit     = 1'b0;
    wr_code      = 1'b0;
    ev           = kcl_pkg::EV_NONE;
    case (key) inside
      [4'd0:kcl_pkg::KEY_DIGIT_MAX]: begin
        if (count_r < FULL) begin
          wr_digit  = 1'b1;
          count_nxt = count_r + 1'b1;
          ev        = kcl_pkg::EV_DIGIT;
        end
      end
      kcl_pkg::KEY_HASH: begin
        if (!code_set_r && !set_mode_r) begin
          set_mode_nxt = 1'b1;
          ev           = kcl_pkg::EV_SETMODE;
        end else if (set_mode_r && count_r == FULL) begin
          wr_code      = 1'b1;
          code_set_nxt = 1'b1;
          set_mode_nxt = 1'b0;
          count_nxt    = '0;
          ev           = kcl_pkg::EV_CODESET;
        end
      end
      kcl_pkg::KEY_STAR: begin
        if (code_set_r && count_r == FULL) begin
          count_nxt = '0;
          if (match) begin
            fail_nxt = '0;
            ev       = kcl_pkg::EV_OPEN;
          end else if (fail_inc >= max_failures) begin
            // limit of zero acts like one: the bumped count always reaches it
            fail_nxt = '0;
            ev       = kcl_pkg::EV_LOCKOUT;
          end else begin
            fail_nxt = fail_inc;
            ev       = kcl_pkg::EV_WRONG;
          end
        end else begin
          ev = kcl_pkg::EV_INCOMPLETE;
        end
      end
      default: ev = kcl_pkg::EV_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      code_set_r <= 1'b0;
      set_mode_r <= 1'b0;
      fail_r     <= '0;
    end else if (step) begin
      count_r    <= count_nxt;
      code_set_r <= code_set_nxt;
      set_mode_r <= set_mode_nxt;
      fail_r     <= fail_nxt;
    end
  end

  // digit and code stores hold no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < CODE_LENGTH; i++) begin
      if (step && wr_digit && count_r == CNT_W'(i)) entry_r[i] <= key;
      if (step && wr_code) stored_r[i] <= entry_r[i];
    end
  end

  assign res.ev       = ev;
  assign res.failures = fail_nxt;
  assign res.present  = code_set_nxt;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL)
    else $error("entry count past code length");

  a_mode_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(set_mode_r && code_set_r))
    else $error("set mode active with a code stored");

  a_code_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    code_set_r |=> code_set_r)
    else $error("stored code flag dropped");

  a_open_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && ev == kcl_pkg::EV_OPEN) |=> (fail_r == '0 && count_r == '0))
    else $error("open did not clear failures and entry");

endmodule
`default_nettype wire

@@ sv/keypad_code_lock_unit.sv @@
// Top level of the keypad code lock: input register, lock core, result register.
// Usage:
//   in_key  : one key code per beat (0-9 digit, 10 star, 11 hash, others ignored).
//   out_evt : exactly one result beat per key: event code, failure count after
//             the key, and whether a code is stored.
//   cfg_wr  : writes the failure limit; always ready, write only while idle.
// A key is held in the input register, its result in the result register.
// Throughput: one key per cycle while out_evt.ready is high; the lock state
// updates as a key leaves the input register, so no key waits on the one before.
// Stall: when out_evt.ready is low the result register holds; the input
// register still takes a key if it is empty, then in_key.ready drops until the
// result beat is taken.
// Reset (rst_n low, synchronous): both registers empty, entry buffer empty,
// no code stored, set mode off, failure count zero, limit back to 3.
`timescale 1ns / 1ps
`default_nettype none
module keypad_code_lock_unit #(
  parameter int CODE_LENGTH = kcl_pkg::CODE_LENGTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  kcl_key_if.sink    in_key,
  kcl_evt_if.source  out_evt,
  kcl_cfg_if.sink    cfg_wr
);

  logic                        key_vld_r;
  logic [kcl_pkg::KEY_W-1:0]   key_r;
  logic                        out_vld_r;
  kcl_pkg::kcl_result_t        out_r;
  kcl_pkg::kcl_result_t        res;
  logic [kcl_pkg::FAIL_W-1:0]  max_fail_r;
  logic                        step;
  logic                        in_ready;

  assign step     = key_vld_r && (!out_vld_r || out_evt.ready);
  assign in_ready = !key_vld_r || step;

  assign in_key.ready = in_ready;
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_fail_r <= kcl_pkg::MAX_FAIL_RESET;
    end else if (cfg_wr.valid) begin
      max_fail_r <= cfg_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_vld_r <= 1'b0;
    end else if (in_ready) begin
      key_vld_r <= in_key.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_key.valid) key_r <= in_key.key_code;
  end

  kcl_core #(
    .CODE_LENGTH (CODE_LENGTH)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .key          (key_r),
    .max_failures (max_fail_r),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step) begin
      out_vld_r <= 1'b1;
    end else if (out_evt.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) out_r <= res;
  end

  assign out_evt.valid        = out_vld_r;
  assign out_evt.event_res    = out_r.ev;
  assign out_evt.failures_now = out_r.failures;
  assign out_evt.code_present = out_r.present;

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for the keypad code lock: predicts every result beat and compares it.
`timescale 1ns / 1ps
module testbench;

  localparam int STALL_LIMIT = 2000;

  logic clk;
  logic rst_n;

  kcl_key_if key_bus();
  kcl_evt_if evt_bus();
  kcl_cfg_if cfg_bus();

  keypad_code_lock_unit u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_key  (key_bus),
    .out_evt (evt_bus),
    .cfg_wr  (cfg_bus)
  );

  // predicted lock state
  logic [kcl_pkg::KEY_W-1:0]  lock_entry [kcl_pkg::CODE_LENGTH_DEF];
  logic [kcl_pkg::KEY_W-1:0]  lock_code [kcl_pkg::CODE_LENGTH_DEF];
  int                         lock_entry_cnt;
  logic                       lock_code_set;
  logic                       lock_arming;
  logic [kcl_pkg::FAIL_W-1:0] lock_fail_cnt;
  logic [kcl_pkg::FAIL_W-1:0] lock_fail_limit;

  kcl_pkg::kcl_result_t pending_events[$];

  int  send_idle_pct;
  int  recv_stall_pct;
  bit  keys_held;
  int  keys_sent;
  int  results_seen = 0;
  int  mismatches = 0;
  int  quiet_cycles = 0;
  int  ev_tally [8] = '{default: 0};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic kcl_pkg::kcl_result_t advance_lock(input logic [kcl_pkg::KEY_W-1:0] key);
    kcl_pkg::kcl_result_t r;
    bit                   same;
    r.ev = kcl_pkg::EV_NONE;
    if (key <= kcl_pkg::KEY_DIGIT_MAX) begin
      if (lock_entry_cnt < kcl_pkg::CODE_LENGTH_DEF) begin
        lock_entry[lock_entry_cnt] = key;
        lock_entry_cnt++;
        r.ev = kcl_pkg::EV_DIGIT;
      end
    end else if (key == kcl_pkg::KEY_HASH) begin
      if (!lock_code_set && !lock_arming) begin
        lock_arming = 1'b1;
        r.ev = kcl_pkg::EV_SETMODE;
      end else if (lock_arming && lock_entry_cnt == kcl_pkg::CODE_LENGTH_DEF) begin
        lock_code = lock_entry;
        lock_code_set = 1'b1;
        lock_arming = 1'b0;
        lock_entry_cnt = 0;
        r.ev = kcl_pkg::EV_CODESET;
      end
    end else if (key == kcl_pkg::KEY_STAR) begin
      if (lock_code_set && lock_entry_cnt == kcl_pkg::CODE_LENGTH_DEF) begin
        same = 1'b1;
        for (int i = 0; i < kcl_pkg::CODE_LENGTH_DEF; i++)
          if (lock_entry[i] != lock_code[i]) same = 1'b0;
        if (same) begin
          lock_fail_cnt = '0;
          r.ev = kcl_pkg::EV_OPEN;
        end else begin
          lock_fail_cnt = lock_fail_cnt + 1'b1;
          if (lock_fail_cnt >= lock_fail_limit) begin
            lock_fail_cnt = '0;
            r.ev = kcl_pkg::EV_LOCKOUT;
          end else begin
            r.ev = kcl_pkg::EV_WRONG;
          end
        end
        lock_entry_cnt = 0;
      end else begin
        r.ev = kcl_pkg::EV_INCOMPLETE;
      end
    end
    r.failures = lock_fail_cnt;
    r.present = lock_code_set;
    return r;
  endfunction

  task automatic send_key(input logic [kcl_pkg::KEY_W-1:0] key);
    if (!keys_held) begin
      key_bus.valid <= 1'b1;
      keys_held = 1'b1;
    end
    key_bus.key_code <= key;
    do @(posedge clk); while (!key_bus.ready);
    keys_sent++;
    pending_events.push_back(advance_lock(key));
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      key_bus.valid <= 1'b0;
      keys_held = 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic send_digit();
    logic [kcl_pkg::KEY_W-1:0] d;
    d = kcl_pkg::KEY_W'($urandom_range(9));
    send_key(d);
  endtask

  // park the keypad and let every outstanding result beat come back
  task automatic drain_results();
    if (keys_held) begin
      key_bus.valid <= 1'b0;
      keys_held = 1'b0;
    end
    do @(posedge clk); while (pending_events.size() != 0);
  endtask

  task automatic write_limit(input logic [kcl_pkg::FAIL_W-1:0] lim);
    drain_results();
    cfg_bus.valid <= 1'b1;
    cfg_bus.data <= lim;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    lock_fail_limit = lim;
  endtask

  // top the buffer up to full and press star; a wrong try spoils one of the digits it adds, if it adds any
  task automatic enter_attempt(input bit correct);
    int                        first;
    int                        bad_pos;
    logic [kcl_pkg::KEY_W-1:0] d;
    first = lock_entry_cnt;
    bad_pos = $urandom_range(first, kcl_pkg::CODE_LENGTH_DEF - 1);
    for (int i = first; i < kcl_pkg::CODE_LENGTH_DEF; i++) begin
      d = lock_code[i];
      if (!correct && i == bad_pos)
        d = kcl_pkg::KEY_W'((lock_code[i] + 1 + $urandom_range(8)) % 10);
      send_key(d);
    end
    send_key(kcl_pkg::KEY_STAR);
  endtask

  task automatic test_directed();
    logic [kcl_pkg::KEY_W-1:0] seq[$];
    logic [kcl_pkg::KEY_W-1:0] tail[$];
    seq = '{kcl_pkg::KEY_STAR, kcl_pkg::KEY_HASH, 4'd0, 4'd9, kcl_pkg::KEY_HASH, 4'd3,
            4'd6, 4'd1, kcl_pkg::KEY_HASH, kcl_pkg::KEY_HASH, kcl_pkg::KEY_STAR};
    for (int k = kcl_pkg::KEY_HASH + 1; k < 16; k++) seq.push_back(kcl_pkg::KEY_W'(k));
    tail = '{4'd0, 4'd9, 4'd3, 4'd6, kcl_pkg::KEY_STAR,
             4'd0, 4'd9, 4'd3, 4'd7, kcl_pkg::KEY_STAR};
    foreach (tail[i]) seq.push_back(tail[i]);
    foreach (seq[i]) send_key(seq[i]);
  endtask

  task automatic test_fail_limits();
    logic [kcl_pkg::FAIL_W-1:0] limits[$];
    int                         tries;
    // zero behaves like one: every wrong entry locks out
    limits = '{3'd0, 3'd1, 3'd7, 3'd2};
    foreach (limits[i]) begin
      write_limit(limits[i]);
      tries = (limits[i] == 0) ? 2 : limits[i] + 1;
      repeat (tries) enter_attempt(1'b0);
      enter_attempt(1'b1);
    end
  endtask

  task automatic test_random_traffic(input int n_keys, input int send_pct, input int recv_pct);
    int                        stop_at;
    int                        pick;
    logic [kcl_pkg::KEY_W-1:0] noise;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    stop_at = keys_sent + n_keys;
    while (keys_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        if ($urandom_range(99) < 15) begin
          // overflow: extra digits past a full buffer
          repeat (kcl_pkg::CODE_LENGTH_DEF - lock_entry_cnt + $urandom_range(1, 2))
            send_digit();
          send_key(kcl_pkg::KEY_STAR);
        end else begin
          enter_attempt($urandom_range(99) < 60);
        end
      end else if (pick < 70) begin
        repeat ($urandom_range(1, 3)) send_digit();
        send_key(kcl_pkg::KEY_STAR);
      end else if (pick < 78) begin
        send_key(kcl_pkg::KEY_HASH);
      end else begin
        noise = kcl_pkg::KEY_W'($urandom_range(15));
        send_key(noise);
      end
      if ($urandom_range(99) < 2) drain_results();
    end
  endtask

  always @(posedge clk) begin
    kcl_pkg::kcl_result_t got;
    kcl_pkg::kcl_result_t want;
    if (rst_n && evt_bus.valid && evt_bus.ready) begin
      got.ev = kcl_pkg::event_t'(evt_bus.event_res);
      got.failures = evt_bus.failures_now;
      got.present = evt_bus.code_present;
      results_seen++;
      ev_tally[evt_bus.event_res]++;
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result beat: ev=%0d failures=%0d code=%0b",
                   $realtime, evt_bus.event_res, got.failures, got.present);
      end else begin
        want = pending_events.pop_front();
        if (got.ev !== want.ev || got.failures !== want.failures
            || got.present !== want.present) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] result %0d: expected ev=%s failures=%0d code=%0b, ",
                     $realtime, results_seen, want.ev.name(), want.failures,
                     want.present, "got ev=%0d failures=%0d code=%0b",
                     evt_bus.event_res, got.failures, got.present);
        end
      end
    end
    evt_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((key_bus.valid && key_bus.ready) || (evt_bus.valid && evt_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    lock_entry_cnt = 0;
    lock_code_set = 1'b0;
    lock_arming = 1'b0;
    lock_fail_cnt = '0;
    lock_fail_limit = kcl_pkg::MAX_FAIL_RESET;
    foreach (lock_entry[i]) lock_entry[i] = '0;
    foreach (lock_code[i]) lock_code[i] = '0;
    keys_held = 1'b0;
    keys_sent = 0;
    send_idle_pct = 29;
    recv_stall_pct = 69;
    rst_n <= 1'b0;
    key_bus.valid <= 1'b0;
    key_bus.key_code <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_fail_limits();
    write_limit(kcl_pkg::FAIL_W'($urandom_range(1, 7)));
    test_random_traffic(430, 29, 69);
    write_limit(kcl_pkg::FAIL_W'($urandom_range(1, 7)));
    test_random_traffic(430, 69, 29);
    write_limit(kcl_pkg::FAIL_W'($urandom_range(1, 7)));
    test_random_traffic(430, 0, 0);
    drain_results();
    repeat (5) @(posedge clk);

    $display("Ran %0d keys (digits, star, hash, unused codes) over limits 0..7 and ",
             keys_sent, "three idle mixes;");
    $display("checked %0d results: %0d opens, %0d wrong, %0d lockouts, ",
             results_seen, ev_tally[kcl_pkg::EV_OPEN], ev_tally[kcl_pkg::EV_WRONG],
             ev_tally[kcl_pkg::EV_LOCKOUT], "%0d incomplete, %0d mismatches",
             ev_tally[kcl_pkg::EV_INCOMPLETE], mismatches);
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
